@@ hw/rtl/cfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cfq_pkg
// Word types, command codes and status codes of the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

	localparam int DATA_W = 32;

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_DELETE  = 2'd1;
	localparam logic [1:0] CMD_DISPLAY = 2'd2;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_OVERFLOW = 2'd1;
	localparam logic [1:0] STS_EMPTY    = 2'd2;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] value;
	} cfq_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} cfq_rsp_t;

endpackage

@@ hw/rtl/cfq_ram.sv @@
// ----------------------------------------------------------------------------
// cfq_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cfq_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/circular_fifo_queue_core.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Fixed-depth circular FIFO driven by insert, delete and display commands.
//
//   channel  signals                    word        direction
//   req      req_valid, req_ready, req  cfq_req_t   in
//   rsp      rsp_valid, rsp_ready, rsp  cfq_rsp_t   out
//
// Insert, overflow and empty replies load the output register on accept.
// Delete: the reply waits for the slot read through the RAM's read register.
// Display: the first read starts on accept; held words then follow in order.
// Reset clears head, tail and occupancy; slot contents are not cleared.
// A stalled rsp holds the output register and blocks further commands.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core
	import cfq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  cfq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output cfq_rsp_t rsp
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DATA = 2'b10
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    head_q, tail_q, ptr_q;
	logic [OCC_W-1:0] occ_q, cnt_q;
	logic             rsp_valid_q;
	cfq_rsp_t         rsp_q;

	logic             out_free, accept, full, empty;
	logic             wr_en, rd_en;
	logic [AW-1:0]    rd_addr, head_nxt, tail_nxt, ptr_nxt;
	logic [DATA_W-1:0] rd_data;
	logic             load;
	cfq_rsp_t         load_word;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign full      = (occ_q == OCC_W'(DEPTH));
	assign empty     = (occ_q == '0);

	assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign ptr_nxt  = (ptr_q  == AW'(DEPTH - 1)) ? '0 : ptr_q  + AW'(1);

	// memory port control and result selection
	always_comb begin
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		load      = 1'b0;
		load_word = '{status: STS_OK, data: '0, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.command)
						CMD_INSERT: begin
							load = 1'b1;
							if (full) begin
								load_word.status = STS_OVERFLOW;
							end else begin
								wr_en = 1'b1;
							end
						end
						CMD_DELETE, CMD_DISPLAY: begin
							if (empty) begin
								load             = 1'b1;
								load_word.status = STS_EMPTY;
							end else begin
								rd_en = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_DATA: begin
				if (out_free) begin
					load           = 1'b1;
					load_word.data = rd_data;
					load_word.last = (cnt_q == OCC_W'(1));
					if (cnt_q != OCC_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = ptr_q;
					end
				end
			end
			default: ;
		endcase
	end

	cfq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_W),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (req.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			ptr_q       <= '0;
			occ_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.command)
							CMD_INSERT: begin
								if (!full) begin
									tail_q <= tail_nxt;
									occ_q  <= occ_q + OCC_W'(1);
								end
							end
							CMD_DELETE: begin
								if (!empty) begin
									head_q  <= head_nxt;
									occ_q   <= occ_q - OCC_W'(1);
									cnt_q   <= OCC_W'(1);
									state_q <= S_DATA;
								end
							end
							CMD_DISPLAY: begin
								if (!empty) begin
									ptr_q   <= head_nxt;
									cnt_q   <= occ_q;
									state_q <= S_DATA;
								end
							end
							default: ;
						endcase
					end
				end
				S_DATA: begin
					if (out_free) begin
						if (cnt_q == OCC_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - OCC_W'(1);
							ptr_q <= ptr_nxt;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= load_word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("occupancy above depth");

	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == OCC_W'(DEPTH)) |-> head_q == tail_q)
		else $error("head and tail disagree with occupancy");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DATA |-> !req_ready && cnt_q != '0)
		else $error("command taken during readout");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA && out_free && cnt_q == OCC_W'(1)) |=>
		state_q == S_IDLE && rsp_valid_q && rsp_q.last)
		else $error("readout did not end with last word");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled word overwritten");

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_fifo_queue_core. A queue tracker mirrors
// head, tail, occupancy and slot contents, builds the replies each accepted
// command should cause and matches them in order against the rsp channel.
// Directed corners first, then random insert/delete bursts with displays
// across several sender/receiver idle mixes, including a long rsp hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfq_pkg::*;

	localparam int QDEPTH      = 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 105;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	cfq_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	cfq_rsp_t rsp;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	class queue_tracker;
		logic signed [DATA_W-1:0] slot_mem [QDEPTH];
		int unsigned              head_ptr;
		int unsigned              tail_ptr;
		int unsigned              fill;
		cfq_rsp_t                 expected_replies[$];
		int                       mismatches;

		function new();
			head_ptr   = 0;
			tail_ptr   = 0;
			fill       = 0;
			mismatches = 0;
		endfunction

		function void push_reply(logic [1:0] status, logic signed [DATA_W-1:0] data,
				logic last);
			cfq_rsp_t r;
			r.status = status;
			r.data   = data;
			r.last   = last;
			expected_replies.push_back(r);
		endfunction

		function void note_command(cfq_req_t w);
			int unsigned idx;
			case (w.command)
				CMD_INSERT: begin
					if (fill == QDEPTH) begin
						push_reply(STS_OVERFLOW, '0, 1'b1);
					end else begin
						slot_mem[tail_ptr] = w.value;
						tail_ptr = (tail_ptr + 1) % QDEPTH;
						fill++;
						push_reply(STS_OK, '0, 1'b1);
					end
				end
				CMD_DELETE: begin
					if (fill == 0) begin
						push_reply(STS_EMPTY, '0, 1'b1);
					end else begin
						push_reply(STS_OK, slot_mem[head_ptr], 1'b1);
						head_ptr = (head_ptr + 1) % QDEPTH;
						fill--;
					end
				end
				CMD_DISPLAY: begin
					if (fill == 0) begin
						push_reply(STS_EMPTY, '0, 1'b1);
					end else begin
						idx = head_ptr;
						for (int k = 0; k < fill; k++) begin
							push_reply(STS_OK, slot_mem[idx], k + 1 == fill);
							idx = (idx + 1) % QDEPTH;
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_reply(cfq_rsp_t got);
			cfq_rsp_t exp_r;
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d data %h last %b",
						got.status, got.data, got.last);
				return;
			end
			exp_r = expected_replies.pop_front();
			if (got.status !== exp_r.status || got.data !== exp_r.data
					|| got.last !== exp_r.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp status %0d data %h last %b, ",
						"got status %0d data %h last %b"},
						exp_r.status, exp_r.data, exp_r.last,
						got.status, got.data, got.last);
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	queue_tracker tracker = new();

	circular_fifo_queue_core #(
		.DEPTH(QDEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// rsp side: random stalls, plus a long hold-off when requested
	initial begin
		rsp_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rsp_valid && rsp_ready)
				tracker.check_reply(rsp);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(posedge clk);
		end
	end

	task automatic send_word(input cfq_req_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!req_ready);
		tracker.note_command(w);
	endtask

	task automatic send_cmd(input logic [1:0] cmd, input logic [DATA_W-1:0] v);
		cfq_req_t w;
		w.command = cmd;
		w.value   = v;
		send_word(w);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// bursts lean toward filling or draining so occupancy sweeps end to end
	task automatic run_random(input int count);
		int         sent;
		int         insert_pct;
		int         r;
		logic [1:0] cmd;
		sent       = 0;
		insert_pct = 70;
		while (sent < count) begin
			if (sent % 12 == 0)
				insert_pct = $urandom_range(1) ? 80 : 25;
			r = $urandom_range(99);
			if (r < 3)
				cmd = CMD_UNUSED;
			else if (r < 13)
				cmd = CMD_DISPLAY;
			else
				cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
			send_cmd(cmd, pick_value());
			if (cmd != CMD_UNUSED)
				sent++;
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_INSERT, 32'h7fff_ffff);
		send_cmd(CMD_INSERT, 32'h8000_0000);
		send_cmd(CMD_INSERT, '0);
		send_cmd(CMD_INSERT, '1);
		send_cmd(CMD_DISPLAY, '0);
		repeat (4) send_cmd(CMD_INSERT, $urandom);
		send_cmd(CMD_INSERT, 32'h5555_5555);
		send_cmd(CMD_DISPLAY, '1);
		repeat (8) send_cmd(CMD_DELETE, $urandom);
		send_cmd(CMD_DELETE, '0);
		send_cmd(CMD_DISPLAY, '0);
		send_cmd(CMD_UNUSED, '1);
		send_cmd(CMD_INSERT, 32'haaaa_aaaa);
		send_cmd(CMD_DISPLAY, '0);
		send_cmd(CMD_DELETE, '0);

		run_random(PHASE_WORDS);

		send_idle_pct  = 55;
		recv_stall_pct = 0;
		run_random(PHASE_WORDS);

		send_idle_pct  = 0;
		recv_stall_pct = 55;
		hold_left      = HOLD_CYCLES;
		run_random(PHASE_WORDS);

		send_idle_pct  = 34;
		recv_stall_pct = 34;
		run_random(PHASE_WORDS);

		req_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
